// File: design/sn83_pkg.sv
// Package for the 8.3 short name formatter: store geometry, character codes
// and the small character classification functions.
// No dependencies.
`timescale 1ns / 1ps

package sn83_pkg;

	// Store geometry: eight base bytes, then three extension bytes
	localparam int NameLen = 11;
	localparam logic [3:0] BaseLast = 4'd7;
	localparam logic [3:0] ExtLast = 4'd10;
	localparam logic [3:0] ExtStart = 4'd8;
	localparam logic [3:0] PosLimit = 4'd11;

	// Character codes
	localparam logic [7:0] ChNul = 8'h00;
	localparam logic [7:0] ChSpace = 8'h20;
	localparam logic [7:0] ChDot = 8'h2E;
	localparam logic [7:0] PrintLow = 8'h21;
	localparam logic [7:0] PrintHigh = 8'h7E;
	localparam logic [7:0] CaseGap = 8'h20;

	typedef logic [7:0] byte_t;

	// Flag punctuation that a short name may not hold
	function automatic logic is_banned(input byte_t c);
		return c inside {8'h7C, 8'h3C, 8'h3E, 8'h5E, 8'h2B, 8'h3D, 8'h3F, 8'h2F,
			8'h5B, 8'h5D, 8'h3B, 8'h2C, 8'h2A, 8'h22, 8'h5C};
	endfunction

	// Fold lower-case letters to upper case
	function automatic byte_t to_upper(input byte_t c);
		byte_t r;
		r = c;
		if (c inside {[8'h61:8'h7A]}) begin
			r = c - CaseGap;
		end
		return r;
	endfunction

endpackage

// File: design/short_name_8_3_formatter_top.sv
// A terminating zero byte gives its registered result in the cycle after it is taken.
// Throughput: one byte per cycle; the request is stalled only while a result
// sits in the output register and the receiver does not take it.
// Reset (arst_n low, asynchronous) empties the output register and sets the
// name store to spaces, position to zero, no dot and no failure.
// Depends on sn83_pkg.
`timescale 1ns / 1ps

module short_name_8_3_formatter_top
	import sn83_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        character_valid,
	output logic        character_ready,
	input  logic [7:0]  character,
	output logic        name_valid,
	input  logic        name_ready,
	output logic        name_ok,
	output logic [63:0] name_base,
	output logic [23:0] name_extension
);

	byte_t       store_q [NameLen];
	logic [3:0]  pos_q;
	logic        dot_q;
	logic        failed_q;
	logic        res_valid_q;
	logic        res_ok_q;
	logic [63:0] res_base_q;
	logic [23:0] res_ext_q;

	logic        take;
	logic        is_term;
	logic        is_dot;
	logic [3:0]  limit;
	logic        bad_char;
	byte_t       upper;
	logic        name_good;
	logic [63:0] base_pack;
	logic [23:0] ext_pack;

	// Accept a request whenever the output register is free or being emptied
	assign character_ready = !res_valid_q || name_ready;
	assign take = character_valid && character_ready;

	// Classify the incoming byte
	assign is_term = (character == ChNul);
	assign is_dot = (character == ChDot);
	assign limit = dot_q ? ExtLast : BaseLast;
	assign bad_char = is_banned(character) || (pos_q > limit)
		|| (character < PrintLow) || (character > PrintHigh);
	assign upper = to_upper(character);

	// Pack the stored bytes, first byte most significant
	always_comb begin
		for (int k = 0; k < 8; k++) begin
			base_pack[63 - 8*k -: 8] = store_q[k];
		end
		for (int k = 0; k < 3; k++) begin
			ext_pack[23 - 8*k -: 8] = store_q[8 + k];
		end
	end
	assign name_good = !failed_q && (store_q[0] != ChSpace);

	// Advance the name state on each accepted byte until a failure; clear it on the terminator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NameLen; k++) begin
				store_q[k] <= ChSpace;
			end
			pos_q <= '0;
			dot_q <= 1'b0;
			failed_q <= 1'b0;
		end else if (take) begin
			if (is_term) begin
				for (int k = 0; k < NameLen; k++) begin
					store_q[k] <= ChSpace;
				end
				pos_q <= '0;
				dot_q <= 1'b0;
				failed_q <= 1'b0;
			end else if (!failed_q) begin
				if (is_dot) begin
					if (dot_q) begin
						failed_q <= 1'b1;
					end else begin
						dot_q <= 1'b1;
						pos_q <= ExtStart;
					end
				end else if (bad_char) begin
					failed_q <= 1'b1;
				end else begin
					store_q[pos_q] <= upper;
					pos_q <= pos_q + 4'd1;
				end
			end
		end
	end

	// Hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take && is_term) begin
			res_valid_q <= 1'b1;
		end else if (name_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Load the result payload; an invalid name reads as zeros
	always_ff @(posedge clk) begin
		if (take && is_term) begin
			res_ok_q <= name_good;
			res_base_q <= name_good ? base_pack : 64'd0;
			res_ext_q <= name_good ? ext_pack : 24'd0;
		end
	end

	assign name_valid = res_valid_q;
	assign name_ok = res_ok_q;
	assign name_base = res_base_q;
	assign name_extension = res_ext_q;

`ifndef SYNTHESIS
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= PosLimit)
		else $error("write position beyond the store");

	a_base_pos: assert property (@(posedge clk) disable iff (!arst_n)
		!dot_q |-> pos_q <= ExtStart)
		else $error("base position beyond eight bytes");

	a_ext_pos: assert property (@(posedge clk) disable iff (!arst_n)
		dot_q |-> pos_q >= ExtStart)
		else $error("extension position below its start");

	a_term_clear: assert property (@(posedge clk) disable iff (!arst_n)
		take && is_term |=> name_valid && pos_q == 4'd0 && !dot_q && !failed_q)
		else $error("terminator did not clear state or raise a result");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		name_valid && !name_ok |-> name_base == 64'd0 && name_extension == 24'd0)
		else $error("invalid name carries non-zero bytes");
`endif

endmodule
